>>> rtl/irc_tok_pkg.sv
// Shared types, constants and command name table for the IRC line tokenizer.
package irc_tok_pkg;

    // Design constants
    localparam int MAX_PARAMS    = 15;
    localparam int CMD_BYTES     = 7;
    localparam int NUM_CMDS      = 9;
    localparam int NAME_COLS     = 7;
    localparam int LEN_W         = $clog2(CMD_BYTES + 2);
    localparam int PCNT_W        = $clog2(MAX_PARAMS + 1);
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 4;

    // Characters of interest
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command codes reported at line end
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_UNKNOWN = 4'd10;

    // Byte roles
    typedef enum logic [2:0] {
        ROLE_SEP    = 3'd0,
        ROLE_PREFIX = 3'd1,
        ROLE_CMD    = 3'd2,
        ROLE_MIDDLE = 3'd3,
        ROLE_TRAIL  = 3'd4
    } role_t;

    // Parser phases, one-hot
    typedef enum logic [8:0] {
        PH_START        = 9'b000000001,
        PH_PREFIX       = 9'b000000010,
        PH_AFTER_PREFIX = 9'b000000100,
        PH_SKIP         = 9'b000001000,
        PH_PRECMD       = 9'b000010000,
        PH_CMD          = 9'b000100000,
        PH_GAP          = 9'b001000000,
        PH_MIDDLE       = 9'b010000000,
        PH_TRAIL        = 9'b100000000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [7:0] echo_byte;
        role_t      byte_role;
        logic       token_start;
        logic [3:0] param_index;
        logic       line_done;
        logic [3:0] command_code;
        logic [3:0] param_count;
    } tok_result_t;

    // Known command names, zero padded; code is row index plus one
    localparam logic [7:0] CMD_NAMES [NUM_CMDS][NAME_COLS] = '{
        '{"P", "A", "S", "S", 8'h00, 8'h00, 8'h00},
        '{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00},
        '{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00},
        '{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00},
        '{"M", "O", "D", "E", 8'h00, 8'h00, 8'h00},
        '{"P", "R", "I", "V", "M", "S", "G"},
        '{"K", "I", "C", "K", 8'h00, 8'h00, 8'h00},
        '{"I", "N", "V", "I", "T", "E", 8'h00},
        '{"T", "O", "P", "I", "C", 8'h00, 8'h00}
    };

    localparam logic [LEN_W-1:0] CMD_LENS [NUM_CMDS] = '{
        LEN_W'(4), LEN_W'(4), LEN_W'(4), LEN_W'(4), LEN_W'(4),
        LEN_W'(7), LEN_W'(4), LEN_W'(6), LEN_W'(5)
    };

endpackage

>>> rtl/irc_tok_cmd_match.sv
// Command name matcher: compares the buffered command bytes against the name table.
module irc_tok_cmd_match (
    input  logic [7:0]                    cmd_buf [irc_tok_pkg::CMD_BYTES],
    input  logic [irc_tok_pkg::LEN_W-1:0] cmd_len,
    output logic [3:0]                    cmd_code
);
    import irc_tok_pkg::*;

    // Only bytes below the name length are compared, so stale entries never matter
    always_comb
    begin
        logic hit;
        hit      = 1'b0;
        cmd_code = CMD_NONE;
        if (cmd_len == '0)
        begin
            cmd_code = CMD_NONE;
        end
        else if (cmd_len > LEN_W'(CMD_BYTES))
        begin
            cmd_code = CMD_UNKNOWN;
        end
        else
        begin
            cmd_code = CMD_UNKNOWN;
            for (int k = 0; k < NUM_CMDS; k++)
            begin
                hit = (cmd_len == CMD_LENS[k]);
                for (int i = 0; i < NAME_COLS; i++)
                begin
                    if ((LEN_W'(i) < CMD_LENS[k]) && (cmd_buf[i] != CMD_NAMES[k][i]))
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    cmd_code = 4'(k + 1);
                end
            end
        end
    end

endmodule

>>> rtl/irc_tok_parser.sv
// Line parser: phase state, command buffer and parameter counters; builds one result per byte.
module irc_tok_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               line_byte,
    input  logic                     end_of_line,
    output irc_tok_pkg::tok_result_t result
);
    import irc_tok_pkg::*;

    // Clip a parameter count to the 4-bit index range
    function automatic logic [3:0] clip15(input logic [PCNT_W-1:0] v);
        logic [PCNT_W+3:0] w;
        w = (PCNT_W + 4)'(v);
        return (w > (PCNT_W + 4)'(15)) ? 4'd15 : w[3:0];
    endfunction

    phase_t            phase_reg, phase_next, phase_eff;
    logic [LEN_W-1:0]  cmd_len_reg, cmd_len_next;
    logic [PCNT_W-1:0] params_reg, params_next;
    logic [3:0]        cur_idx_reg, cur_idx_next;
    logic [7:0]        cmd_buf_reg [CMD_BYTES];
    logic [7:0]        cmd_buf_next [CMD_BYTES];
    logic              cmd_wr, param_start, is_space, is_colon;
    role_t             role;
    logic              tstart;
    logic [3:0]        pidx;
    logic [3:0]        cmd_code;

    assign is_space = (line_byte == CH_SPACE);
    assign is_colon = (line_byte == CH_COLON);

    // Phase decode and byte classification
    always_comb
    begin
        phase_next  = phase_reg;
        phase_eff   = phase_reg;
        role        = ROLE_SEP;
        tstart      = 1'b0;
        pidx        = 4'd0;
        cmd_wr      = 1'b0;
        param_start = 1'b0;

        // line start and the byte after the prefix may fall into the command
        case (phase_reg)
            PH_START:
            begin
                if (is_colon)
                begin
                    role       = ROLE_PREFIX;
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    phase_eff = PH_PRECMD;
                end
            end
            PH_AFTER_PREFIX:
            begin
                if (is_colon)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    phase_eff = PH_PRECMD;
                end
            end
            default:
            begin
            end
        endcase

        case (phase_eff)
            PH_PREFIX:
            begin
                if (is_space)
                begin
                    phase_next = PH_AFTER_PREFIX;
                end
                else
                begin
                    role = ROLE_PREFIX;
                end
            end
            PH_SKIP:
            begin
                if (is_space)
                begin
                    phase_next = PH_PRECMD;
                end
            end
            PH_PRECMD, PH_CMD:
            begin
                if (is_space)
                begin
                    phase_next = (phase_eff == PH_CMD) ? PH_GAP : PH_PRECMD;
                end
                else
                begin
                    cmd_wr     = 1'b1;
                    role       = ROLE_CMD;
                    phase_next = PH_CMD;
                end
            end
            PH_GAP:
            begin
                if (!is_space)
                begin
                    param_start = 1'b1;
                    tstart      = 1'b1;
                    pidx        = clip15(params_reg);
                    role        = is_colon ? ROLE_TRAIL : ROLE_MIDDLE;
                    phase_next  = is_colon ? PH_TRAIL : PH_MIDDLE;
                end
            end
            PH_MIDDLE:
            begin
                if (is_space)
                begin
                    phase_next = PH_GAP;
                end
                else
                begin
                    role = ROLE_MIDDLE;
                    pidx = cur_idx_reg;
                end
            end
            PH_TRAIL:
            begin
                role = ROLE_TRAIL;
                pidx = cur_idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Parameter counters
    always_comb
    begin
        cur_idx_next = param_start ? clip15(params_reg) : cur_idx_reg;
        params_next  = params_reg;
        if (param_start && (params_reg < PCNT_W'(MAX_PARAMS)))
        begin
            params_next = params_reg + 1'b1;
        end
    end

    // Command length saturates one past the buffer size
    always_comb
    begin
        cmd_len_next = cmd_len_reg;
        if (cmd_wr && (cmd_len_reg <= LEN_W'(CMD_BYTES)))
        begin
            cmd_len_next = cmd_len_reg + 1'b1;
        end
        for (int i = 0; i < CMD_BYTES; i++)
        begin
            cmd_buf_next[i] = (cmd_wr && (cmd_len_reg == LEN_W'(i))) ? line_byte
                                                                       : cmd_buf_reg[i];
        end
    end

    irc_tok_cmd_match u_match (
        .cmd_buf  (cmd_buf_next),
        .cmd_len  (cmd_len_next),
        .cmd_code (cmd_code)
    );

    // Result for this byte
    always_comb
    begin
        result.echo_byte    = line_byte;
        result.byte_role    = role;
        result.token_start  = tstart;
        result.param_index  = pidx;
        result.line_done    = end_of_line;
        result.command_code = end_of_line ? cmd_code : CMD_NONE;
        result.param_count  = end_of_line ? clip15(params_next) : 4'd0;
    end

    // Control state; line end returns everything to line start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            cmd_len_reg <= '0;
            params_reg  <= '0;
            cur_idx_reg <= 4'd0;
        end
        else if (step)
        begin
            if (end_of_line)
            begin
                phase_reg   <= PH_START;
                cmd_len_reg <= '0;
                params_reg  <= '0;
                cur_idx_reg <= 4'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                cmd_len_reg <= cmd_len_next;
                params_reg  <= params_next;
                cur_idx_reg <= cur_idx_next;
            end
        end
    end

    // Command bytes, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cmd_buf_reg <= cmd_buf_next;
        end
    end

endmodule

>>> rtl/irc_line_tokenizer.sv
// Top level of the IRC line tokenizer: input stage, parser and output register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = line_byte, s_tlast = end_of_line
//  m_*       out  m_tvalid/m_tready  m_tdata = echo/index/code/count, m_tuser = role/start,
//                                    m_tlast = line_done
//
// One item per cycle sustained while m_* is not stalled; a byte reaches m_* once the output register takes it.
// The input register feeds the parser, whose short logic lands in the output register.
// rst_n clears the handshake valids and puts the parser at line start.
// A stall on m_tready holds the output register; an empty input register still takes one
// more item, then s_tready stays low until the output side moves.
module irc_line_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [irc_tok_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] line_byte
    input  logic                              s_tlast,  // end_of_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [irc_tok_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] echo_byte, [11:8] param_index,
                                                        // [15:12] command_code,
                                                        // [19:16] param_count, [23:20] zero
    output logic [irc_tok_pkg::M_TUSER_W-1:0] m_tuser,  // [2:0] byte_role, [3] token_start
    output logic                              m_tlast   // line_done
);
    import irc_tok_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    tok_result_t out_res_reg;
    tok_result_t res;
    logic        out_free, step;

    // Pipeline advance
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    irc_tok_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .line_byte   (in_byte_reg),
        .end_of_line (in_last_reg),
        .result      (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    // Port packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.param_count, out_res_reg.command_code,
                       out_res_reg.param_index, out_res_reg.echo_byte};
    assign m_tuser  = {out_res_reg.token_start, out_res_reg.byte_role};
    assign m_tlast  = out_res_reg.line_done;

endmodule

>>> rtl/irc_tok_checker.sv
// Port-level checks for the IRC line tokenizer, bound to the top level.
module irc_tok_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [irc_tok_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [irc_tok_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [irc_tok_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                              m_tlast
);
    import irc_tok_pkg::*;

    // A waiting input item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("input item changed while waiting");

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
    else $error("result item changed while stalled");

    // Command code and count only appear on the last byte of a line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[19:12] == 8'd0)
    else $error("line summary outside line end");

    // Index and token start only on parameter bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] != ROLE_MIDDLE) && (m_tuser[2:0] != ROLE_TRAIL)
        |-> (m_tdata[11:8] == 4'd0) && !m_tuser[3])
    else $error("parameter index on a non-parameter byte");

    // A space is either a separator or part of the trailing text
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:0] == CH_SPACE)
        |-> (m_tuser[2:0] == ROLE_SEP) || (m_tuser[2:0] == ROLE_TRAIL))
    else $error("space given a token role");

endmodule

bind irc_line_tokenizer irc_tok_checker u_checker (.*);
